// ===== rtl/bmp_palette_pixel_expander_unit_defines.svh =====
// ----------------------------------------------------------------------------
// bmp palette pixel expander assertion macros
// shared property shapes for the concurrent checks of the expander
// ----------------------------------------------------------------------------
`ifndef BMP_PALETTE_PIXEL_EXPANDER_UNIT_DEFINES_SVH
`define BMP_PALETTE_PIXEL_EXPANDER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define BPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpe_pkg
// types, codes and sizes shared by the palette pixel expander
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

  localparam int MAX_ROW_WIDTH = 8192;
  localparam int PALETTE_DEPTH = 256;

  localparam int IDX_W   = $clog2(PALETTE_DEPTH);
  localparam int COLOR_W = 24;
  localparam int ROW_W   = 14;
  localparam int MODE_W  = 2;

  // pixel count within a row, up to the maximum width itself
  localparam int PIX_W = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CMP_W = (PIX_W > ROW_W) ? PIX_W : ROW_W;
  // row bits at eight bits per pixel, and the rounded 32-bit word count
  localparam int BITS_W = PIX_W + 3;
  localparam int WORD_W = BITS_W + 1;
  // longest padded row in bytes
  localparam int LB_MAX = ((MAX_ROW_WIDTH * 8 + 31) / 32) * 4;
  localparam int LB_W   = $clog2(LB_MAX + 1);
  localparam int BP_W   = $clog2(LB_MAX);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_DEPTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH        = 2'd1;

  localparam logic [MODE_W-1:0] MODE_1BIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_4BIT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_8BIT = 2'd2;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 14'd640;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_DATA    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] entry_index;
    logic [7:0] entry_blue;
    logic [7:0] entry_green;
    logic [7:0] entry_red;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic       row_end;
    logic       last_of_byte;
  } out_item_t;

  // palette write port: color packed red, green, blue from msb
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
  } wr_req_t;

  // palette lookup with the flags that ride along to the output
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    logic             row_end;
    logic             last;
  } rd_req_t;

endpackage

`default_nettype wire

// ===== rtl/bmp_palette_pixel_expander_unit.sv =====
// pixel path: byte sequencer register, palette read stage, then output register
// throughput: one pixel per cycle from the single palette read port while output
//   is not stalled; a byte gives up to 8 pixels at one bit, 2 at four, 1 at eight bits
// a palette write transaction returns no pixel
// reset (synchronous, active high) clears row positions, sets depth to eight bits and
//   row width to 640; palette contents are undefined until written, no clearing pass
// ----------------------------------------------------------------------------
// bmp_palette_pixel_expander_unit
// unpacks indexed row bytes and expands each index through the palette
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_palette_pixel_expander_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              byte_valid,
  output logic                             byte_ready,
  input  wire bpe_pkg::in_item_t           byte_item,
  output logic                             pixel_valid,
  input  wire                              pixel_ready,
  output bpe_pkg::out_item_t               pixel_item,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [bpe_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bpe_pkg::*;

  // configuration registers
  logic [MODE_W-1:0] pixel_depth_mode;
  logic [ROW_W-1:0]  row_width;

  // row tracking, already advanced past every accepted data byte
  logic [PIX_W-1:0] pixel_position;
  logic [BP_W-1:0]  byte_position;

  // sequencer for the byte being expanded
  logic              busy;
  logic [7:0]        cur_byte;
  logic [MODE_W-1:0] cur_depth;
  logic [2:0]        k;
  logic [2:0]        k_last;
  logic              cur_row_end;

  // per-transaction decode
  logic [MODE_W-1:0] depth_sel;
  logic [PIX_W-1:0]  width;
  logic [BITS_W-1:0] row_bits;
  logic [WORD_W-1:0] row_words;
  logic [LB_W-1:0]   line_bytes;
  logic [LB_W-1:0]   bp_inc;
  logic              row_done;
  logic [PIX_W-1:0]  remaining;
  logic [3:0]        per_byte;
  logic [3:0]        count;
  logic [PIX_W-1:0]  pix_after;
  logic              byte_row_end;

  logic    accept;
  logic    issue;
  logic    issue_ok;
  logic    at_last;
  wr_req_t wr;
  rd_req_t rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth_mode <= MODE_8BIT;
      row_width        <= ROW_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PIXEL_DEPTH_MODE: pixel_depth_mode <= cfg_data[MODE_W-1:0];
        CFG_ROW_WIDTH:        row_width        <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width counts as one, wider than the maximum saturates
  always_comb begin
    if (row_width == '0) begin
      width = PIX_W'(1);
    end else if (CMP_W'(row_width) > CMP_W'(MAX_ROW_WIDTH)) begin
      width = PIX_W'(MAX_ROW_WIDTH);
    end else begin
      width = PIX_W'(row_width);
    end
  end

  // selector three behaves as eight bits
  always_comb begin
    case (pixel_depth_mode)
      MODE_1BIT: begin
        depth_sel = MODE_1BIT;
        per_byte  = 4'd8;
        row_bits  = BITS_W'(width);
      end
      MODE_4BIT: begin
        depth_sel = MODE_4BIT;
        per_byte  = 4'd2;
        row_bits  = BITS_W'(width) << 2;
      end
      default: begin
        depth_sel = MODE_8BIT;
        per_byte  = 4'd1;
        row_bits  = BITS_W'(width) << 3;
      end
    endcase
  end

  // padded row length: bits rounded up to 32, in bytes
  assign row_words  = (WORD_W'(row_bits) + WORD_W'(31)) >> 5;
  assign line_bytes = LB_W'(row_words) << 2;
  assign bp_inc     = LB_W'(byte_position) + LB_W'(1);
  assign row_done   = bp_inc >= line_bytes;

  // pixels this byte still owes to the row
  assign remaining = (pixel_position >= width) ? '0 : width - pixel_position;
  assign count     = (remaining >= PIX_W'(per_byte)) ? per_byte : remaining[3:0];
  assign pix_after = pixel_position + PIX_W'(count);
  // only the final pixel of a byte can close the row
  assign byte_row_end = (count != 4'd0) && (pix_after == width);

  assign at_last    = (k == k_last);
  assign issue      = busy && issue_ok;
  assign byte_ready = !busy || (issue && at_last);
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      byte_position  <= '0;
    end else if (accept && byte_item.kind == KIND_DATA) begin
      if (row_done) begin
        pixel_position <= '0;
        byte_position  <= '0;
      end else begin
        pixel_position <= pix_after;
        byte_position  <= BP_W'(bp_inc);
      end
    end
  end

  // one palette lookup per cycle while a byte is held and the read stage has room
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= (byte_item.kind == KIND_DATA) && (count != 4'd0);
    end else if (issue && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte    <= byte_item.data_byte;
      cur_depth   <= depth_sel;
      k           <= 3'd0;
      k_last      <= 3'(count - 4'd1);
      cur_row_end <= byte_row_end;
    end else if (issue) begin
      k <= k + 3'd1;
    end
  end

  // index select: msb first at one bit, high nibble first at four
  always_comb begin
    rd.en      = issue;
    rd.row_end = cur_row_end && at_last;
    rd.last    = at_last;
    case (cur_depth)
      MODE_1BIT: rd.index = IDX_W'(cur_byte[3'd7 - k]);
      MODE_4BIT: rd.index = (k == 3'd0) ? IDX_W'(cur_byte[7:4]) : IDX_W'(cur_byte[3:0]);
      default:   rd.index = IDX_W'(cur_byte);
    endcase
  end

  always_comb begin
    wr.en    = accept && (byte_item.kind == KIND_PALETTE);
    wr.index = IDX_W'(byte_item.entry_index);
    wr.color = {byte_item.entry_red, byte_item.entry_green, byte_item.entry_blue};
  end

  bpe_palette u_palette (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .rd          (rd),
    .issue_ok    (issue_ok),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_item  (pixel_item)
  );

endmodule

`default_nettype wire

// ===== rtl/bpe_palette.sv =====
// ----------------------------------------------------------------------------
// bpe_palette
// palette memory with registered lookup and an output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp_palette_pixel_expander_unit_defines.svh"

module bpe_palette (
  input  wire                 clk,
  input  wire                 rst,
  input  wire bpe_pkg::wr_req_t wr,
  input  wire bpe_pkg::rd_req_t rd,
  output logic                issue_ok,
  output logic                pixel_valid,
  input  wire                 pixel_ready,
  output bpe_pkg::out_item_t  pixel_item
);
  import bpe_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [COLOR_W-1:0] rdata;
  logic               s1_valid;
  logic               s1_row_end;
  logic               s1_last;
  logic               out_free;
  logic               s1_adv;

  assign out_free = !pixel_valid || pixel_ready;
  assign s1_adv   = s1_valid && out_free;
  assign issue_ok = !s1_valid || out_free;

  // read before write on the same edge keeps order with earlier lookups
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.index] <= wr.color;
    end
    if (rd.en) begin
      rdata <= mem[rd.index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (rd.en) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      s1_row_end <= rd.row_end;
      s1_last    <= rd.last;
    end
    if (s1_adv) begin
      pixel_item.pixel_blue   <= rdata[7:0];
      pixel_item.pixel_green  <= rdata[15:8];
      pixel_item.pixel_red    <= rdata[23:16];
      pixel_item.row_end      <= s1_row_end;
      pixel_item.last_of_byte <= s1_last;
    end
  end

  `BPE_ASSERT_NOW(a_read_has_slot, clk, rst, rd.en, issue_ok, "lookup issued into a full stage")
  `BPE_ASSERT_NEXT(a_read_lands, clk, rst, rd.en, s1_valid, "lookup did not reach read stage")
  `BPE_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !out_free, s1_valid && $stable(rdata),
    "read stage lost data while stalled")

endmodule

`default_nettype wire
